// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/plc_pkg.sv -----
package plc_pkg;

  // register indexes
  localparam logic [2:0] RegMinValid   = 3'd0;
  localparam logic [2:0] RegMediumRange = 3'd1;
  localparam logic [2:0] RegCloseRange = 3'd2;
  localparam logic [2:0] RegOutDelay   = 3'd3;
  localparam logic [2:0] RegMediumLevel = 3'd4;
  localparam logic [2:0] RegFullLevel  = 3'd5;
  localparam logic [2:0] RegFadeTime   = 3'd6;

  // reset values
  localparam logic [13:0] MinValidReset    = 14'd30;
  localparam logic [13:0] MediumRangeReset = 14'd750;
  localparam logic [13:0] CloseRangeReset  = 14'd500;
  localparam logic [15:0] OutDelayReset    = 16'd5000;
  localparam logic [7:0]  MediumLevelReset = 8'd30;
  localparam logic [7:0]  FullLevelReset   = 8'd255;
  localparam logic [15:0] FadeTimeReset    = 16'd1000;

  // sensor characters
  localparam logic [7:0] CharR    = 8'h52;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // frame phases: idle, then digits one to four
  localparam logic [2:0] PhaseIdle   = 3'd0;
  localparam logic [2:0] PhaseDigit1 = 3'd1;
  localparam logic [2:0] PhaseDigit4 = 3'd4;

  // zone codes
  localparam logic [1:0] ZoneOut    = 2'd0;
  localparam logic [1:0] ZoneMedium = 2'd1;
  localparam logic [1:0] ZoneClose  = 2'd2;

  // out-of-range countdown
  localparam int unsigned TimerWidth = 16;
  localparam logic [63:0] TimerMaxWide = (64'd1 << TimerWidth) - 64'd1;

  typedef struct packed {
    logic [13:0] min_valid_mm;
    logic [13:0] medium_range_mm;
    logic [13:0] close_range_mm;
    logic [15:0] out_delay_ms;
    logic [7:0]  medium_level;
    logic [7:0]  full_level;
    logic [15:0] fade_time_ms;
  } cfg_t;

  typedef struct packed {
    logic        fade_start;
    logic [7:0]  fade_level;
    logic [15:0] fade_duration;
    logic [1:0]  zone;
  } zone_res_t;

endpackage

// ----- hdl/proximity_light_controller_core.sv -----
// proximity light controller: takes one transfer per cycle on the slave side, each carrying
// an optional sensor byte and an optional millisecond tick, parses frames of 'R' plus four
// ascii digits into a distance in mm, sorts it into out, medium or close zones and issues a
// fade request on entering a zone or when the out-of-range delay expires; every accepted
// transfer yields exactly one result transfer. an item is evaluated while it sits in the
// input register and is then registered into the result register once that register can
// take it; a new item is taken every cycle while the result side keeps up; a stalled
// result holds the input register until it drains.
// the seven thresholds and levels sit behind the apb port at byte addresses 4*i and are read
// back unchanged; writes are meant only while the block is idle.
`include "assert_macros.svh"

module proximity_light_controller_core (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_valid, rx_byte[7:0], ms_tick, zero pad
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // fade_start, fade_level[7:0], fade_duration[15:0],
                                 // zone[1:0], distance_out[13:0], zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  plc_pkg::cfg_t      cfg;
  plc_pkg::zone_res_t zone_res;

  logic        in_valid;
  logic [9:0]  in_data;       // input register payload
  logic        advance;       // result register can take a new result
  logic        step_en;       // state moves on with the item leaving the input register
  logic [13:0] distance_next;
  logic        cfg_write;
  logic [2:0]  reg_index;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_valid_mm    <= plc_pkg::MinValidReset;
      cfg.medium_range_mm <= plc_pkg::MediumRangeReset;
      cfg.close_range_mm  <= plc_pkg::CloseRangeReset;
      cfg.out_delay_ms    <= plc_pkg::OutDelayReset;
      cfg.medium_level    <= plc_pkg::MediumLevelReset;
      cfg.full_level      <= plc_pkg::FullLevelReset;
      cfg.fade_time_ms    <= plc_pkg::FadeTimeReset;
    end else if (cfg_write) begin
      case (reg_index)
        plc_pkg::RegMinValid:    cfg.min_valid_mm    <= pwdata[13:0];
        plc_pkg::RegMediumRange: cfg.medium_range_mm <= pwdata[13:0];
        plc_pkg::RegCloseRange:  cfg.close_range_mm  <= pwdata[13:0];
        plc_pkg::RegOutDelay:    cfg.out_delay_ms    <= pwdata[15:0];
        plc_pkg::RegMediumLevel: cfg.medium_level    <= pwdata[7:0];
        plc_pkg::RegFullLevel:   cfg.full_level      <= pwdata[7:0];
        plc_pkg::RegFadeTime:    cfg.fade_time_ms    <= pwdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      plc_pkg::RegMinValid:    prdata = {18'd0, cfg.min_valid_mm};
      plc_pkg::RegMediumRange: prdata = {18'd0, cfg.medium_range_mm};
      plc_pkg::RegCloseRange:  prdata = {18'd0, cfg.close_range_mm};
      plc_pkg::RegOutDelay:    prdata = {16'd0, cfg.out_delay_ms};
      plc_pkg::RegMediumLevel: prdata = {24'd0, cfg.medium_level};
      plc_pkg::RegFullLevel:   prdata = {24'd0, cfg.full_level};
      plc_pkg::RegFadeTime:    prdata = {16'd0, cfg.fade_time_ms};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // two-register pipeline: input register, then result register
  // ---------------------------------------------------------------------------
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step_en  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata[9:0];
    end
  end

  // frame parser, holds the last complete distance
  plc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .en            (step_en),
    .byte_valid    (in_data[0]),
    .rx_byte       (in_data[8:1]),
    .distance_next (distance_next)
  );

  // zone tracking and out-of-range countdown
  plc_zone u_zone (
    .clk      (clk),
    .rst      (rst),
    .en       (step_en),
    .ms_tick  (in_data[9]),
    .distance (distance_next),
    .cfg      (cfg),
    .res      (zone_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      m_tdata <= {7'd0, distance_next, zone_res.zone, zone_res.fade_duration,
                  zone_res.fade_level, zone_res.fade_start};
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // no fade means zero level and duration
  `ASSERT_CLK(a_no_fade_zero, m_tvalid && !m_tdata[0] |-> m_tdata[24:1] == '0, "stray fade")
  // zone code three is never produced
  `ASSERT_CLK(a_zone_code, m_tvalid |-> m_tdata[26:25] != 2'd3, "bad zone code on result")
  // a waiting item is not lost while the result side stalls
  `ASSERT_CLK(a_hold_item, in_valid && m_tvalid && !m_tready |=> in_valid, "input item dropped")
  // an empty result register never blocks the input side
  `ASSERT_CLK(a_ready_empty, !m_tvalid |-> s_tready, "input stalled while empty")

endmodule

// ----- hdl/plc_parser.sv -----
module plc_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        byte_valid,
  input  logic [7:0]  rx_byte,
  output logic [13:0] distance_next
);

  logic [2:0]  frame_phase, frame_phase_next;
  logic [13:0] partial_value, partial_value_next;
  logic [13:0] distance_mm;
  logic        digit;
  logic [13:0] times_ten;

  assign digit = (rx_byte >= plc_pkg::CharZero) && (rx_byte <= plc_pkg::CharNine);
  // value * 10 as two shifts, kept to 14 bits
  assign times_ten = (partial_value << 3) + (partial_value << 1);

  always_comb begin
    frame_phase_next   = frame_phase;
    partial_value_next = partial_value;
    distance_next      = distance_mm;
    if (byte_valid) begin
      if (frame_phase >= plc_pkg::PhaseDigit1 && frame_phase <= plc_pkg::PhaseDigit4 &&
          digit) begin
        partial_value_next = times_ten + {10'd0, rx_byte[3:0]};
        if (frame_phase == plc_pkg::PhaseDigit4) begin
          distance_next    = partial_value_next;
          frame_phase_next = plc_pkg::PhaseIdle;
        end else begin
          frame_phase_next = frame_phase + 3'd1;
        end
      end else if (rx_byte == plc_pkg::CharR) begin
        frame_phase_next   = plc_pkg::PhaseDigit1;
        partial_value_next = '0;
      end else begin
        frame_phase_next = plc_pkg::PhaseIdle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase   <= plc_pkg::PhaseIdle;
      partial_value <= '0;
      distance_mm   <= '0;
    end else if (en) begin
      frame_phase   <= frame_phase_next;
      partial_value <= partial_value_next;
      distance_mm   <= distance_next;
    end
  end

endmodule

// ----- hdl/plc_zone.sv -----
module plc_zone (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               ms_tick,
  input  logic [13:0]        distance,
  input  plc_pkg::cfg_t      cfg,
  output plc_pkg::zone_res_t res
);

  logic [1:0]                      zone_now, zone_now_next;
  logic                            timer_armed, timer_armed_next;
  logic [plc_pkg::TimerWidth-1:0]  countdown, countdown_next;
  logic [plc_pkg::TimerWidth-1:0]  count_ticked;
  logic [plc_pkg::TimerWidth-1:0]  load_value;
  logic                            start;
  logic [7:0]                      level;

  // saturate the delay to what the timer can hold
  always_comb begin
    if (64'(cfg.out_delay_ms) > plc_pkg::TimerMaxWide) begin
      load_value = plc_pkg::TimerMaxWide[plc_pkg::TimerWidth-1:0];
    end else begin
      load_value = plc_pkg::TimerWidth'(cfg.out_delay_ms);
    end
  end

  always_comb begin
    count_ticked = countdown;
    if (ms_tick && timer_armed && countdown != '0) begin
      count_ticked = countdown - plc_pkg::TimerWidth'(1);
    end
    zone_now_next    = zone_now;
    timer_armed_next = timer_armed;
    countdown_next   = count_ticked;
    start            = 1'b0;
    level            = '0;
    if (distance > cfg.min_valid_mm) begin
      if (distance > cfg.medium_range_mm) begin
        if (zone_now_next != plc_pkg::ZoneOut) begin
          zone_now_next    = plc_pkg::ZoneOut;
          timer_armed_next = 1'b1;
          countdown_next   = load_value;
        end else if (timer_armed_next && count_ticked == '0) begin
          timer_armed_next = 1'b0;
          start            = 1'b1;
          level            = '0;
        end
      end
      if (distance <= cfg.medium_range_mm && distance > cfg.close_range_mm &&
          zone_now_next == plc_pkg::ZoneOut) begin
        zone_now_next    = plc_pkg::ZoneMedium;
        timer_armed_next = 1'b0;
        countdown_next   = '0;
        start            = 1'b1;
        level            = cfg.medium_level;
      end
      // close wins when thresholds cross
      if (zone_now_next != plc_pkg::ZoneClose && distance <= cfg.close_range_mm) begin
        zone_now_next    = plc_pkg::ZoneClose;
        timer_armed_next = 1'b0;
        countdown_next   = '0;
        start            = 1'b1;
        level            = cfg.full_level;
      end
    end
    res.fade_start    = start;
    res.fade_level    = start ? level : 8'd0;
    res.fade_duration = start ? cfg.fade_time_ms : 16'd0;
    res.zone          = zone_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_now    <= plc_pkg::ZoneOut;
      timer_armed <= 1'b0;
      countdown   <= '0;
    end else if (en) begin
      zone_now    <= zone_now_next;
      timer_armed <= timer_armed_next;
      countdown   <= countdown_next;
    end
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plc_pkg::*;

  // one result transfer as it appears on m_tdata, lowest field last in the list
  typedef struct packed {
    logic [13:0] mm;
    logic [1:0]  zone;
    logic [15:0] dur;
    logic [7:0]  level;
    logic        start;
  } light_res_t;

  // one row of the directed stimulus; known rows carry a typed-in result
  typedef struct {
    logic       bv;
    logic [7:0] b;
    logic       tick;
    bit         known;
    light_res_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // byte_valid, rx_byte[7:0], ms_tick, zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // fade_start, fade_level[7:0], fade_duration[15:0],
                          // zone[1:0], distance_out[13:0], zero pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  proximity_light_controller_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the limit registers, starting from their reset values
  cfg_t shadow_cfg = '{
    min_valid_mm:    MinValidReset,
    medium_range_mm: MediumRangeReset,
    close_range_mm:  CloseRangeReset,
    out_delay_ms:    OutDelayReset,
    medium_level:    MediumLevelReset,
    full_level:      FullLevelReset,
    fade_time_ms:    FadeTimeReset
  };

  // predicted controller state
  logic [2:0]            rd_phase  = PhaseIdle;
  logic [13:0]           rd_accum  = '0;
  logic [13:0]           last_mm   = '0;
  logic [1:0]            cur_zone  = ZoneOut;
  logic                  dim_armed = 1'b0;
  logic [TimerWidth-1:0] dim_count = '0;

  light_res_t expected_lights[$];
  stim_row_t  directed_rows[$];

  // what the transfer now on the slave side should produce, if typed in
  bit         row_known;
  light_res_t row_result;

  int errors     = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_fades    = 0;
  int n_dims     = 0;
  int n_settings = 0;
  int burst_left = 0;
  bit steady     = 1'b0;
  int tick_pct   = 30;

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the shadow controller by one transfer and return its result
  function automatic light_res_t advance_lights(input logic bv, input logic [7:0] b,
                                                input logic tick);
    light_res_t r;
    logic       start;
    logic [7:0] lvl;
    logic [13:0] d;
    start = 1'b0;
    lvl   = '0;
    // tick first, only an armed and nonzero countdown moves
    if (tick && dim_armed && dim_count != 0) dim_count--;
    // then the sensor byte
    if (bv) begin
      if (rd_phase >= PhaseDigit1 && rd_phase <= PhaseDigit4 &&
          b >= CharZero && b <= CharNine) begin
        rd_accum = 14'(rd_accum * 10 + (b - CharZero));
        if (rd_phase == PhaseDigit4) begin
          last_mm  = rd_accum;
          rd_phase = PhaseIdle;
        end else begin
          rd_phase = rd_phase + 3'd1;
        end
      end else if (b == CharR) begin
        // start of frame, also restarts a frame cut short
        rd_phase = PhaseDigit1;
        rd_accum = '0;
      end else begin
        rd_phase = PhaseIdle;
      end
    end
    // zone logic on the latest complete reading
    d = last_mm;
    if (d > shadow_cfg.min_valid_mm) begin
      if (d > shadow_cfg.medium_range_mm) begin
        if (cur_zone != ZoneOut) begin
          // leaving range arms the dimming delay
          cur_zone  = ZoneOut;
          dim_armed = 1'b1;
          if (64'(shadow_cfg.out_delay_ms) > TimerMaxWide) dim_count = '1;
          else dim_count = TimerWidth'(shadow_cfg.out_delay_ms);
        end else if (dim_armed && dim_count == 0) begin
          dim_armed = 1'b0;
          start     = 1'b1;
          lvl       = '0;
          n_dims++;
        end
      end
      if (d <= shadow_cfg.medium_range_mm && d > shadow_cfg.close_range_mm &&
          cur_zone == ZoneOut) begin
        cur_zone  = ZoneMedium;
        dim_armed = 1'b0;
        dim_count = '0;
        start     = 1'b1;
        lvl       = shadow_cfg.medium_level;
      end
      // close actions come last and win over the out-of-range ones
      if (cur_zone != ZoneClose && d <= shadow_cfg.close_range_mm) begin
        cur_zone  = ZoneClose;
        dim_armed = 1'b0;
        dim_count = '0;
        start     = 1'b1;
        lvl       = shadow_cfg.full_level;
      end
    end
    r.start = start;
    r.level = start ? lvl : 8'd0;
    r.dur   = start ? shadow_cfg.fade_time_ms : 16'd0;
    r.zone  = cur_zone;
    r.mm    = last_mm;
    return r;
  endfunction

  // gap before the next transfer: bursts of random length, random pauses
  function automatic int next_gap();
    if (steady) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 32);
    return $urandom_range(1, 10);
  endfunction

  function automatic logic roll_tick();
    return $urandom_range(0, 99) < tick_pct;
  endfunction

  // distance near the current thresholds, or anywhere in range
  function automatic int pick_mm();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = shadow_cfg.min_valid_mm;
      2: v = shadow_cfg.min_valid_mm + 1;
      3: v = shadow_cfg.close_range_mm;
      4: v = shadow_cfg.close_range_mm + 1;
      5: v = shadow_cfg.medium_range_mm;
      6: v = shadow_cfg.medium_range_mm + 1;
      7: v = 9999;
      default: v = $urandom_range(0, 9999);
    endcase
    if (v > 9999) v = 9999;
    return v;
  endfunction

  // one slave transfer, driven at the falling edge, held until taken
  task automatic push_reading(input logic bv, input logic [7:0] b, input logic tick,
                              input bit known, input light_res_t res);
    int gap;
    @(negedge clk);
    s_tvalid   <= 1'b1;
    s_tdata    <= {6'b0, tick, b, bv};
    row_known  <= known;
    row_result <= res;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_reading(1'b1, b, roll_tick(), 1'b0, '0);
  endtask

  // hold the sender until every expected result is back, then let the pipe settle
  task automatic wait_for_lights(input int limit);
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_lights.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_lights.size() != 0) begin
      errors += expected_lights.size();
      $error("%0d expected results never arrived", expected_lights.size());
      expected_lights.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // apb write followed by a readback of the same register
  task automatic write_limit(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      RegMinValid:    shadow_cfg.min_valid_mm    = val[13:0];
      RegMediumRange: shadow_cfg.medium_range_mm = val[13:0];
      RegCloseRange:  shadow_cfg.close_range_mm  = val[13:0];
      RegOutDelay:    shadow_cfg.out_delay_ms    = val[15:0];
      RegMediumLevel: shadow_cfg.medium_level    = val[7:0];
      RegFullLevel:   shadow_cfg.full_level      = val[7:0];
      RegFadeTime:    shadow_cfg.fade_time_ms    = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read setup straight after the write access
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) begin
      errors++;
      $error("readback of register %0d: expected %0d, got %0d", idx, val, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(input int min_mm, input int med_mm, input int close_mm,
                            input int delay, input int med_lvl, input int full_lvl,
                            input int fade);
    write_limit(RegMinValid,    32'(min_mm));
    write_limit(RegMediumRange, 32'(med_mm));
    write_limit(RegCloseRange,  32'(close_mm));
    write_limit(RegOutDelay,    32'(delay));
    write_limit(RegMediumLevel, 32'(med_lvl));
    write_limit(RegFullLevel,   32'(full_lvl));
    write_limit(RegFadeTime,    32'(fade));
    n_settings++;
  endtask

  // mostly well-formed frames with random distances, plus ticks, noise and broken frames
  task automatic run_phase(input int count);
    int         first;
    int         mm;
    int         sel;
    int         k;
    logic [7:0] bad;
    first    = n_sent;
    steady   = ($urandom_range(0, 3) == 0);
    tick_pct = $urandom_range(10, 80);
    while (n_sent - first < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        mm = pick_mm();
        send_byte(CharR);
        send_byte(8'(CharZero + mm / 1000));
        send_byte(8'(CharZero + (mm / 100) % 10));
        send_byte(8'(CharZero + (mm / 10) % 10));
        send_byte(8'(CharZero + mm % 10));
        // a run of bare ticks lets the dimming delay run out
        repeat ($urandom_range(0, 12))
          push_reading(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end else if (sel < 85) begin
        push_reading(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        // frame cut short by a non-digit, sometimes a fresh start character
        send_byte(CharR);
        k = $urandom_range(0, 3);
        repeat (k) send_byte(8'(CharZero + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          bad = CharR;
        end else begin
          do bad = 8'($urandom_range(0, 255)); while (bad >= CharZero && bad <= CharNine);
        end
        send_byte(bad);
      end
    end
  endtask

  task automatic add_row(input logic bv, input logic [7:0] b, input logic tick,
                         input bit known, input light_res_t res);
    stim_row_t r;
    r.bv    = bv;
    r.b     = b;
    r.tick  = tick;
    r.known = known;
    r.res   = res;
    directed_rows.push_back(r);
  endtask

  // compare each result transfer with the oldest expectation, then queue the next one
  always @(posedge clk) begin : lights_check
    light_res_t got;
    light_res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = light_res_t'(m_tdata[40:0]);
        if (expected_lights.size() == 0) begin
          errors++;
          $error("result transfer with nothing expected");
        end else begin
          want = expected_lights.pop_front();
          n_checked++;
          if (got.start) n_fades++;
          if (got.start !== want.start) begin
            errors++;
            $error("fade_start: expected %0d, got %0d", want.start, got.start);
          end
          if (got.level !== want.level) begin
            errors++;
            $error("fade_level: expected %0d, got %0d", want.level, got.level);
          end
          if (got.dur !== want.dur) begin
            errors++;
            $error("fade_duration: expected %0d, got %0d", want.dur, got.dur);
          end
          if (got.zone !== want.zone) begin
            errors++;
            $error("zone: expected %0d, got %0d", want.zone, got.zone);
          end
          if (got.mm !== want.mm) begin
            errors++;
            $error("distance_out: expected %0d, got %0d", want.mm, got.mm);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = advance_lights(s_tdata[0], s_tdata[8:1], s_tdata[9]);
        if (row_known) want = row_result;
        expected_lights.push_back(want);
      end
    end
  end

  // result side stalls on its own pattern, including long stretches always ready
  initial begin : result_sink
    int run;
    int pct;
    m_tready = 1'b0;
    forever begin
      run = $urandom_range(1, 60);
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 70;
        2: pct = 40;
        default: pct = 10;
      endcase
      repeat (run) begin
        @(negedge clk);
        m_tready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    light_res_t none;
    none       = '0;
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    row_known  = 1'b0;
    row_result = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    // directed part under the reset limits
    // first transfer after reset: nothing seen yet
    add_row(1'b0, 8'h00, 1'b0, 1'b1, '{start: 1'b0, level: 8'd0, dur: 16'd0,
                                       zone: ZoneOut, mm: 14'd0});
    // byte extremes between frames are ignored, tick with nothing armed
    add_row(1'b1, 8'h00, 1'b1, 1'b0, none);
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, none);
    // reading at or below the minimum changes nothing
    add_row(1'b1, CharR, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero, 1'b1, 1'b0, none);
    add_row(1'b1, CharZero, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero + 8'd2, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero + 8'd5, 1'b0, 1'b1, '{start: 1'b0, level: 8'd0, dur: 16'd0,
                                                 zone: ZoneOut, mm: 14'd25});
    // non-digit just above nine drops the frame
    add_row(1'b1, CharR, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero + 8'd1, 1'b0, 1'b0, none);
    add_row(1'b1, CharNine + 8'd1, 1'b0, 1'b0, none);
    // start character inside a frame restarts it, then medium range
    add_row(1'b1, CharR, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero + 8'd1, 1'b0, 1'b0, none);
    add_row(1'b1, CharR, 1'b1, 1'b0, none);
    add_row(1'b1, CharZero, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero + 8'd6, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero, 1'b0, 1'b0, none);
    add_row(1'b1, CharZero, 1'b0, 1'b1, '{start: 1'b1, level: 8'd30, dur: 16'd1000,
                                          zone: ZoneMedium, mm: 14'd600});
    // trailing carriage return
    add_row(1'b1, 8'h0D, 1'b1, 1'b0, none);
    // largest reading leaves range and arms the delay
    add_row(1'b1, CharR, 1'b0, 1'b0, none);
    add_row(1'b1, CharNine, 1'b0, 1'b0, none);
    add_row(1'b1, CharNine, 1'b1, 1'b0, none);
    add_row(1'b1, CharNine, 1'b0, 1'b0, none);
    add_row(1'b1, CharNine, 1'b0, 1'b1, '{start: 1'b0, level: 8'd0, dur: 16'd0,
                                          zone: ZoneOut, mm: 14'd9999});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_reading(directed_rows[i].bv, directed_rows[i].b, directed_rows[i].tick,
                   directed_rows[i].known, directed_rows[i].res);
    wait_for_lights(20000);

    // random part, one limit setting per phase with a full drain in between
    set_limits(30, 750, 500, 3, 30, 255, 1000);
    run_phase(172);
    wait_for_lights(20000);
    // lowest values everywhere but the medium range at 9999, zero delay
    set_limits(0, 9999, 0, 0, 0, 0, 0);
    run_phase(172);
    wait_for_lights(20000);
    // highest values everywhere, no reading can be valid
    set_limits(9999, 9999, 9999, 65535, 255, 255, 65535);
    run_phase(172);
    wait_for_lights(20000);
    // close edge beyond medium edge
    set_limits(100, 500, 800, 2, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 65535));
    run_phase(172);
    wait_for_lights(20000);
    set_limits(200, 2000, 1000, 10, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 65535));
    run_phase(172);
    wait_for_lights(20000);
    repeat (3) begin
      set_limits($urandom_range(0, 300), $urandom_range(0, 4000), $urandom_range(0, 3000),
                 $urandom_range(0, 12), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 65535));
      run_phase(172);
      wait_for_lights(20000);
    end

    wait_for_lights(2000);
    repeat (10) @(posedge clk);

    $display("covered %0d sensor transfers under %0d limit settings, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("fades seen: %0d, of which %0d after the out-of-range delay ran out",
             n_fades, n_dims);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/plc_pkg.sv
hdl/plc_parser.sv
hdl/plc_zone.sv
hdl/proximity_light_controller_core.sv
test/tb_top.sv
